>>> rtl/ita_pkg.sv
`default_nettype none
package ita_pkg;

  typedef enum logic [2:0] {
    MODE_ALLOC = 3'd0,
    MODE_FREE  = 3'd1,
    MODE_SCHED = 3'd2,
    MODE_OPEN  = 3'd3,
    MODE_CLOSE = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    RC_OK    = 3'd0,
    RC_FULL  = 3'd1,
    RC_RANGE = 3'd2,
    RC_SCHED = 3'd3,
    RC_OVER  = 3'd4,
    RC_UNDER = 3'd5
  } result_t;

  localparam int MODE_W = 3;
  localparam int CODE_W = 3;
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_NORMAL = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DELETE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNINIT = 2'd2;

  // control from the execute logic to the sequencer
  typedef struct packed {
    logic    wr_en;
    logic    freed;
    result_t code;
  } exec_ctl_t;

endpackage
`default_nettype wire

>>> rtl/ita_entry_ram.sv
`default_nettype none
module ita_entry_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 29
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/ita_exec.sv
`default_nettype none
module ita_exec #(
  parameter int IDX_W  = 10,
  parameter int CAP_W  = 11,
  parameter int REF_W  = 16,
  parameter int WORD_W = 29
) (
  input  wire ita_pkg::mode_t     mode,
  input  wire logic [IDX_W-1:0]   addr,
  input  wire logic [IDX_W-1:0]   free_head,
  input  wire logic               free_nonempty,
  input  wire logic [CAP_W-1:0]   bump_count,
  input  wire logic [CAP_W-1:0]   cap_eff,
  input  wire logic [WORD_W-1:0]  rd_word,
  output ita_pkg::exec_ctl_t      ctl,
  output logic [WORD_W-1:0]       wr_word,
  output logic [IDX_W-1:0]        alloc_out,
  output logic [REF_W-1:0]        cnt_out,
  output logic [IDX_W-1:0]        free_head_next,
  output logic                    free_nonempty_next,
  output logic [CAP_W-1:0]        bump_count_next
);

  // entry word: {link valid, link, status, count}
  localparam int ST_LSB   = REF_W;
  localparam int LINK_LSB = REF_W + ita_pkg::STAT_W;
  localparam int LV_BIT   = LINK_LSB + IDX_W;

  logic [REF_W-1:0]           cnt;
  logic [ita_pkg::STAT_W-1:0] stat;
  logic [IDX_W-1:0]           link;
  logic                       link_valid;
  logic [REF_W-1:0]           cnt_dec;
  logic                       in_range;

  assign cnt        = rd_word[REF_W-1:0];
  assign stat       = rd_word[LINK_LSB-1:ST_LSB];
  assign link       = rd_word[LV_BIT-1:LINK_LSB];
  assign link_valid = rd_word[LV_BIT];
  assign cnt_dec    = cnt - 1'b1;
  assign in_range   = {{(CAP_W-IDX_W){1'b0}}, addr} < bump_count;

  always_comb begin
    ctl                = '0;
    ctl.code           = ita_pkg::RC_OK;
    wr_word            = rd_word;
    alloc_out          = '0;
    cnt_out            = '0;
    free_head_next     = free_head;
    free_nonempty_next = free_nonempty;
    bump_count_next    = bump_count;
    case (mode)
      ita_pkg::MODE_ALLOC: begin
        if (free_nonempty || bump_count < cap_eff) begin
          ctl.wr_en                    = 1'b1;
          wr_word[LV_BIT]              = 1'b0;
          wr_word[LINK_LSB-1:ST_LSB]   = ita_pkg::STAT_NORMAL;
          wr_word[REF_W-1:0]           = '0;
          alloc_out                    = addr;
          if (free_nonempty) begin
            free_head_next     = link;
            free_nonempty_next = link_valid;
          end else begin
            bump_count_next = bump_count + 1'b1;
          end
        end else begin
          ctl.code = ita_pkg::RC_FULL;
        end
      end
      ita_pkg::MODE_FREE, ita_pkg::MODE_SCHED, ita_pkg::MODE_OPEN,
      ita_pkg::MODE_CLOSE: begin
        if (!in_range) begin
          ctl.code = ita_pkg::RC_RANGE;
        end else begin
          cnt_out = cnt;
          case (mode)
            ita_pkg::MODE_FREE: begin
              ctl.wr_en                  = 1'b1;
              ctl.freed                  = 1'b1;
              wr_word[LV_BIT]            = free_nonempty;
              wr_word[LV_BIT-1:LINK_LSB] = free_head;
              wr_word[LINK_LSB-1:ST_LSB] = ita_pkg::STAT_UNINIT;
              free_head_next             = addr;
              free_nonempty_next         = 1'b1;
            end
            ita_pkg::MODE_SCHED: begin
              if (stat != ita_pkg::STAT_NORMAL) begin
                ctl.code = ita_pkg::RC_SCHED;
              end else begin
                ctl.wr_en                  = 1'b1;
                wr_word[LINK_LSB-1:ST_LSB] = ita_pkg::STAT_DELETE;
              end
            end
            ita_pkg::MODE_OPEN: begin
              if (&cnt) begin
                ctl.code = ita_pkg::RC_OVER;
              end else begin
                ctl.wr_en          = 1'b1;
                wr_word[REF_W-1:0] = cnt + 1'b1;
                cnt_out            = cnt + 1'b1;
              end
            end
            default: begin
              if (cnt == '0) begin
                ctl.code = ita_pkg::RC_UNDER;
              end else begin
                ctl.wr_en          = 1'b1;
                wr_word[REF_W-1:0] = cnt_dec;
                cnt_out            = cnt_dec;
                // last close of an entry marked for deletion returns it
                if (cnt_dec == '0 && stat == ita_pkg::STAT_DELETE) begin
                  ctl.freed                  = 1'b1;
                  wr_word[LV_BIT]            = free_nonempty;
                  wr_word[LV_BIT-1:LINK_LSB] = free_head;
                  wr_word[LINK_LSB-1:ST_LSB] = ita_pkg::STAT_UNINIT;
                  free_head_next             = addr;
                  free_nonempty_next         = 1'b1;
                end
              end
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/inode_table_allocator.sv
// The entry is read on accept and the result is registered on execute.
// A new request is accepted only after the current one has executed, set by
// the read-modify-write of the single entry memory (read on accept, write back
// on execute); a result left waiting in the output register holds the execute
// step until taken.
// Reset: free list empty, bump counter zero, capacity = ENTRIES; entry memory not cleared.
`default_nettype none
module inode_table_allocator #(
  parameter int ENTRIES  = 1024,
  parameter int REF_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                capacity_we,
  input  wire logic [$clog2(ENTRIES):0] capacity_wdata,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // mode, entry_index
  input  wire logic [((ita_pkg::MODE_W+$clog2(ENTRIES)+7)/8)*8-1:0] s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // result_code, allocated_index, entry_freed, ref_count_out
  output logic [((ita_pkg::CODE_W+$clog2(ENTRIES)+1+REF_BITS+7)/8)*8-1:0] m_tdata
);

  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CAP_W    = IDX_W + 1;
  localparam int WORD_W   = 1 + IDX_W + ita_pkg::STAT_W + REF_BITS;
  localparam int OUT_W    = ((ita_pkg::CODE_W + IDX_W + 1 + REF_BITS + 7) / 8) * 8;
  localparam int ALLOC_LSB = ita_pkg::CODE_W;
  localparam int FREED_BIT = ALLOC_LSB + IDX_W;
  localparam int CNT_LSB   = FREED_BIT + 1;
  localparam logic [CAP_W-1:0] ENTRIES_C = CAP_W'(ENTRIES);

  typedef enum logic {IDLE, EXEC} state_t;

  state_t             state;
  logic [CAP_W-1:0]   capacity;
  logic [CAP_W-1:0]   cap_eff;
  logic [IDX_W-1:0]   free_head;
  logic               free_nonempty;
  logic [CAP_W-1:0]   bump_count;
  ita_pkg::mode_t     req_mode;
  logic [IDX_W-1:0]   req_addr;

  ita_pkg::mode_t     in_mode;
  logic [IDX_W-1:0]   in_idx;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic [WORD_W-1:0]  rd_word;
  logic               exec_go;

  ita_pkg::exec_ctl_t ctl;
  logic [WORD_W-1:0]  wr_word;
  logic [IDX_W-1:0]   alloc_out;
  logic [REF_BITS-1:0] cnt_out;
  logic [IDX_W-1:0]   free_head_next;
  logic               free_nonempty_next;
  logic [CAP_W-1:0]   bump_count_next;
  logic [OUT_W-1:0]   m_tdata_next;

  assign in_mode  = ita_pkg::mode_t'(s_tdata[ita_pkg::MODE_W-1:0]);
  assign in_idx   = s_tdata[ita_pkg::MODE_W+IDX_W-1:ita_pkg::MODE_W];
  assign s_tready = (state == IDLE);
  assign rd_en    = s_tvalid && s_tready;
  assign cap_eff  = (capacity > ENTRIES_C) ? ENTRIES_C : capacity;
  // the result register may still hold an earlier result; wait for it
  assign exec_go  = (state == EXEC) && (!m_tvalid || m_tready);

  // allocate reads the free-list head, or the bump slot it would take
  always_comb begin
    if (in_mode == ita_pkg::MODE_ALLOC) begin
      rd_addr = free_nonempty ? free_head : bump_count[IDX_W-1:0];
    end else begin
      rd_addr = in_idx;
    end
  end

  ita_entry_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word),
    .wr_en   (exec_go && ctl.wr_en),
    .wr_addr (req_addr),
    .wr_data (wr_word)
  );

  ita_exec #(
    .IDX_W  (IDX_W),
    .CAP_W  (CAP_W),
    .REF_W  (REF_BITS),
    .WORD_W (WORD_W)
  ) u_exec (
    .mode               (req_mode),
    .addr               (req_addr),
    .free_head          (free_head),
    .free_nonempty      (free_nonempty),
    .bump_count         (bump_count),
    .cap_eff            (cap_eff),
    .rd_word            (rd_word),
    .ctl                (ctl),
    .wr_word            (wr_word),
    .alloc_out          (alloc_out),
    .cnt_out            (cnt_out),
    .free_head_next     (free_head_next),
    .free_nonempty_next (free_nonempty_next),
    .bump_count_next    (bump_count_next)
  );

  always_comb begin
    m_tdata_next                              = '0;
    m_tdata_next[ita_pkg::CODE_W-1:0]         = ctl.code;
    m_tdata_next[FREED_BIT-1:ALLOC_LSB]       = alloc_out;
    m_tdata_next[FREED_BIT]                   = ctl.freed;
    m_tdata_next[CNT_LSB+REF_BITS-1:CNT_LSB]  = cnt_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      m_tvalid      <= 1'b0;
      capacity      <= ENTRIES_C;
      free_head     <= '0;
      free_nonempty <= 1'b0;
      bump_count    <= '0;
    end else begin
      if (capacity_we) begin
        capacity <= capacity_wdata;
      end
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            req_mode <= in_mode;
            req_addr <= rd_addr;
            state    <= EXEC;
          end
        end
        EXEC: begin
          if (exec_go) begin
            m_tdata       <= m_tdata_next;
            free_head     <= free_head_next;
            free_nonempty <= free_nonempty_next;
            bump_count    <= bump_count_next;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
